>>> src/grid_tile_view_window_defines.svh
// Assertion macros shared by the grid tile view window RTL
`ifndef GRID_TILE_VIEW_WINDOW_DEFINES_SVH
`define GRID_TILE_VIEW_WINDOW_DEFINES_SVH
`ifndef SYNTH
`define GTVW_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define GTVW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GTVW_ASSERT(label, cond, msg)
`define GTVW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> src/gtvw_pkg.sv
// Shared types and constants of the grid tile view window block
package gtvw_pkg;

  localparam int COORD_W   = 16;
  localparam int SIDE_W    = 5;
  localparam int RANGE_W   = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = 4;
  localparam int TILE_W    = 8;
  localparam int MAX_SIDE  = 16;

  localparam int ROWS_RESET  = 11;
  localparam int COLS_RESET  = 8;
  localparam int RANGE_RESET = 800;

  // Squared move that forces a recompute, and the smallest single-axis step
  // whose square alone reaches it.
  localparam int MOVE_THRESHOLD = 400;
  localparam int MOVE_LIMIT     = 20;

  // Most tiles sent for one camera position, own tile included.
  localparam int OUT_MAX = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS  = 2'd0,
    REG_GRID_COLS  = 2'd1,
    REG_VIEW_RANGE = 2'd2
  } cfg_reg_t;

  // One tile list, as the back end walks it.
  typedef struct packed {
    logic [IDX_W-1:0]  top;
    logic [IDX_W-1:0]  bottom;
    logic [SIDE_W-1:0] cols;
    logic [TILE_W-1:0] first_tile;
    logic [TILE_W-1:0] own_tile;
    logic [TILE_W-1:0] last_tile;
  } job_t;

endpackage

>>> src/gtvw_front.sv
// Front end: move check, tile index search and window update per camera item
module gtvw_front #(
  parameter int TILE_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                hold,
  input  logic [gtvw_pkg::SIDE_W-1:0]         grid_rows,
  input  logic [gtvw_pkg::SIDE_W-1:0]         grid_cols,
  input  logic [gtvw_pkg::RANGE_W-1:0]        view_range,
  input  logic                                cam_valid,
  output logic                                cam_stall,
  input  logic signed [gtvw_pkg::COORD_W-1:0] cam_x,
  input  logic signed [gtvw_pkg::COORD_W-1:0] cam_y,
  input  logic signed [gtvw_pkg::COORD_W-1:0] cam_z,
  output logic                                push,
  output gtvw_pkg::job_t                      push_job,
  input  logic                                full
);
  import gtvw_pkg::*;

  localparam int HALF    = TILE_WIDTH / 2;
  localparam int CW      = $clog2(65536 + MAX_SIDE * TILE_WIDTH) + 1;
  localparam int IW      = IDX_W + 1;
  localparam int DW      = COORD_W + 1;
  localparam int SMALL_W = $clog2(MOVE_LIMIT) + 1;
  localparam int SUM_W   = $clog2(3 * MOVE_LIMIT * MOVE_LIMIT);

  function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] n);
    if (n == '0) return SIDE_W'(1);
    else if (n > SIDE_W'(MAX_SIDE)) return SIDE_W'(MAX_SIDE);
    else return n;
  endfunction

  // Index of the last tile edge strictly below u, or -1. The hits form a
  // thermometer code, so the top hit is found by independent compares.
  function automatic logic signed [IW-1:0] idx_of(input logic signed [CW-1:0] u,
                                                   input logic [SIDE_W-1:0] n);
    logic [MAX_SIDE-1:0] hit;
    logic [MAX_SIDE-1:0] hit_up;
    logic [MAX_SIDE-1:0] top_hit;
    logic [IDX_W-1:0]    pos;
    for (int i = 0; i < MAX_SIDE; i++) begin
      hit[i] = (SIDE_W'(i) < n) && (u > CW'(i * TILE_WIDTH));
    end
    hit_up  = {1'b0, hit[MAX_SIDE-1:1]};
    top_hit = hit & ~hit_up;
    pos = '0;
    for (int i = 0; i < MAX_SIDE; i++) begin
      if (top_hit[i]) pos = pos | IDX_W'(i);
    end
    return hit[0] ? {1'b0, pos} : '1;
  endfunction

  function automatic logic far_step(input logic signed [DW-1:0] d);
    return (d >= DW'(MOVE_LIMIT)) || (d <= -DW'(MOVE_LIMIT));
  endfunction

  // Square of a step known to be short; far steps are caught separately.
  function automatic logic [SUM_W-1:0] sq_small(input logic signed [DW-1:0] d);
    logic signed [SMALL_W-1:0]   s;
    logic signed [2*SMALL_W-1:0] p;
    s = d[SMALL_W-1:0];
    p = s * s;
    return SUM_W'(p);
  endfunction

  function automatic logic [TILE_W-1:0] tile_of(input logic [IDX_W-1:0] c,
                                                input logic [IDX_W-1:0] r,
                                                input logic [SIDE_W-1:0] n);
    return TILE_W'(c) + TILE_W'(r) * TILE_W'(n);
  endfunction

  // Grid offsets, registered from the configuration registers.
  logic [SIDE_W-1:0]    rows_sat, cols_sat;
  logic signed [CW-1:0] col_off, col_lo, col_hi, row_off, row_lo, row_hi;
  logic [SIDE_W-1:0]    rows_n, cols_n;
  logic signed [CW-1:0] col_off_n, row_off_n, range_s;

  assign rows_n    = sat_side(grid_rows);
  assign cols_n    = sat_side(grid_cols);
  assign col_off_n = CW'(cols_n) * CW'(HALF);
  assign row_off_n = CW'(rows_n) * CW'(HALF);
  assign range_s   = CW'(view_range);

  always_ff @(posedge clk) begin
    rows_sat <= rows_n;
    cols_sat <= cols_n;
    col_off  <= col_off_n;
    col_lo   <= col_off_n - range_s;
    col_hi   <= col_off_n + range_s;
    row_off  <= row_off_n;
    row_lo   <= row_off_n - range_s;
    row_hi   <= row_off_n + range_s;
  end

  // Stage 1: camera and the six shifted positions. Rows count along -z.
  logic                        s1_valid;
  logic signed [COORD_W-1:0]   s1_x, s1_y, s1_z;
  logic signed [CW-1:0]        s1_uc, s1_ul, s1_ur, s1_vc, s1_vt, s1_vb;
  logic signed [CW-1:0]        xe, ze;

  // Stage 2: tile indices and the move decision.
  logic                        s2_valid;
  logic                        s2_move;
  logic signed [IW-1:0]        s2_cx, s2_cz, s2_l, s2_r, s2_t, s2_b;

  logic signed [COORD_W-1:0]   prev_x, prev_y, prev_z;
  logic                        first_pending;
  logic                        list_valid;
  job_t                        list_job;

  logic signed [DW-1:0]        dx, dy, dz;
  logic [SUM_W-1:0]            sum_sq;
  logic                        move;
  logic                        adv;
  logic                        fix;
  logic                        s2_push;
  logic [IDX_W-1:0]            left_c, top_c;
  job_t                        new_job;

  assign xe = CW'(cam_x);
  assign ze = CW'(cam_z);

  assign dx     = DW'(s1_x) - DW'(prev_x);
  assign dy     = DW'(s1_y) - DW'(prev_y);
  assign dz     = DW'(s1_z) - DW'(prev_z);
  assign sum_sq = sq_small(dx) + sq_small(dy) + sq_small(dz);
  assign move   = first_pending || far_step(dx) || far_step(dy) || far_step(dz) ||
                  (sum_sq >= SUM_W'(MOVE_THRESHOLD));

  // Keep the old list while the camera is off the grid.
  assign fix    = s2_move && !s2_cx[IW-1] && !s2_cz[IW-1];
  assign left_c = s2_l[IW-1] ? '0 : s2_l[IDX_W-1:0];
  assign top_c  = s2_t[IW-1] ? '0 : s2_t[IDX_W-1:0];

  always_comb begin
    new_job.top        = top_c;
    new_job.bottom     = s2_b[IDX_W-1:0];
    new_job.cols       = cols_sat;
    new_job.first_tile = tile_of(left_c, top_c, cols_sat);
    new_job.own_tile   = tile_of(s2_cx[IDX_W-1:0], s2_cz[IDX_W-1:0], cols_sat);
    new_job.last_tile  = tile_of(s2_r[IDX_W-1:0], s2_b[IDX_W-1:0], cols_sat);
  end

  assign s2_push   = fix || list_valid;
  assign push_job  = fix ? new_job : list_job;
  assign adv       = !(s2_valid && s2_push && full);
  assign push      = s2_valid && s2_push && !full;
  assign cam_stall = hold || !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      first_pending <= 1'b1;
      list_valid    <= 1'b0;
      prev_x        <= '0;
      prev_y        <= '0;
      prev_z        <= '0;
    end else if (adv) begin
      s1_valid <= cam_valid && !cam_stall;
      s2_valid <= s1_valid;
      if (s1_valid && move) begin
        first_pending <= 1'b0;
        prev_x        <= s1_x;
        prev_y        <= s1_y;
        prev_z        <= s1_z;
      end
      if (s2_valid && fix) list_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x  <= cam_x;
      s1_y  <= cam_y;
      s1_z  <= cam_z;
      s1_uc <= xe + col_off;
      s1_ul <= xe + col_lo;
      s1_ur <= xe + col_hi;
      s1_vc <= row_off - ze;
      s1_vt <= row_lo - ze;
      s1_vb <= row_hi - ze;
      s2_move <= move;
      s2_cx   <= idx_of(s1_uc, cols_sat);
      s2_l    <= idx_of(s1_ul, cols_sat);
      s2_r    <= idx_of(s1_ur, cols_sat);
      s2_cz   <= idx_of(s1_vc, rows_sat);
      s2_t    <= idx_of(s1_vt, rows_sat);
      s2_b    <= idx_of(s1_vb, rows_sat);
      if (s2_valid && fix) list_job <= new_job;
    end
  end

endmodule

>>> src/gtvw_queue.sv
// Two-entry list queue between the front end and the tile emitter
module gtvw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gtvw_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output gtvw_pkg::job_t pop_job,
  output logic           avail
);
  import gtvw_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  job_t            slot [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count;

  assign full    = count == (PW+1)'(DEPTH);
  assign avail   = count != '0;
  assign pop_job = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_job;
  end

endmodule

>>> src/gtvw_back.sv
// Back end: walks a tile list column by column and sends one tile a cycle while tile_stall is low
module gtvw_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          avail,
  input  gtvw_pkg::job_t                q_job,
  output logic                          pop,
  output logic                          tile_valid,
  input  logic                          tile_stall,
  output logic [gtvw_pkg::TILE_W-1:0]   tile_index,
  output logic                          is_last
);
  import gtvw_pkg::*;

  localparam int CNT_W = $clog2(OUT_MAX);

  logic              busy;
  job_t              job;
  logic [IDX_W-1:0]  row;
  logic [TILE_W-1:0] cur;
  logic [TILE_W-1:0] col_start;
  logic [CNT_W-1:0]  cnt;
  logic              produce;
  logic              at_end;

  // The own tile closes the list at the last window slot or once the
  // list is cut short.
  assign produce = busy && (!tile_valid || !tile_stall);
  assign at_end  = (cur == job.last_tile) || (cnt == CNT_W'(OUT_MAX - 1));
  assign pop     = avail && (!busy || (produce && at_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      tile_valid <= 1'b0;
    end else begin
      if (produce) tile_valid <= 1'b1;
      else if (!tile_stall) tile_valid <= 1'b0;
      if (pop) busy <= 1'b1;
      else if (produce && at_end) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      if (at_end) begin
        tile_index <= job.own_tile;
        is_last    <= 1'b1;
      end else begin
        // Swap: the own tile's slot takes the last tile of the window.
        tile_index <= (cur == job.own_tile) ? job.last_tile : cur;
        is_last    <= 1'b0;
        cnt        <= cnt + 1'b1;
        if (row == job.bottom) begin
          row       <= job.top;
          col_start <= col_start + 1'b1;
          cur       <= col_start + 1'b1;
        end else begin
          row <= row + 1'b1;
          cur <= cur + TILE_W'(job.cols);
        end
      end
    end
    if (pop) begin
      job       <= q_job;
      row       <= q_job.top;
      cur       <= q_job.first_tile;
      col_start <= q_job.first_tile;
      cnt       <= '0;
    end
  end

endmodule

>>> src/grid_tile_view_window.sv
// Top level of the grid tile view window block
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_en                 cfg_index, cfg_data
//   cam      in         cam_valid / cam_stall  cam_x, cam_y, cam_z
//   tile     out        tile_valid / tile_stall tile_index, is_last
//
// A camera item is registered in the front end's stages before its list enters the list queue.
// The emitter sends min(n, 9) tiles for a window of n tiles, one per cycle while
// tile_stall is low, with no gap between lists; that emitter sets the item rate.
// The front end takes a new item every cycle while the two-entry queue has room.
// A configuration write holds cam_stall high for the following cycle.
// Reset is synchronous; it restores register defaults and empties the queue.
`include "grid_tile_view_window_defines.svh"

module grid_tile_view_window #(
  parameter int TILE_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_en,
  input  logic [gtvw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gtvw_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                cam_valid,
  output logic                                cam_stall,
  input  logic signed [gtvw_pkg::COORD_W-1:0] cam_x,
  input  logic signed [gtvw_pkg::COORD_W-1:0] cam_y,
  input  logic signed [gtvw_pkg::COORD_W-1:0] cam_z,
  output logic                                tile_valid,
  input  logic                                tile_stall,
  output logic [gtvw_pkg::TILE_W-1:0]         tile_index,
  output logic                                is_last
);
  import gtvw_pkg::*;

  logic [SIDE_W-1:0]  grid_rows, grid_cols;
  logic [RANGE_W-1:0] view_range;
  logic               cfg_settle;

  logic               q_push, q_full, q_pop, q_avail;
  job_t               q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows  <= SIDE_W'(ROWS_RESET);
      grid_cols  <= SIDE_W'(COLS_RESET);
      view_range <= RANGE_W'(RANGE_RESET);
      cfg_settle <= 1'b0;
    end else begin
      cfg_settle <= cfg_en;
      if (cfg_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_GRID_ROWS:  grid_rows  <= cfg_data[SIDE_W-1:0];
          REG_GRID_COLS:  grid_cols  <= cfg_data[SIDE_W-1:0];
          REG_VIEW_RANGE: view_range <= cfg_data[RANGE_W-1:0];
          default:        ;
        endcase
      end
    end
  end

  gtvw_front #(
    .TILE_WIDTH(TILE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (cfg_settle),
    .grid_rows (grid_rows),
    .grid_cols (grid_cols),
    .view_range(view_range),
    .cam_valid (cam_valid),
    .cam_stall (cam_stall),
    .cam_x     (cam_x),
    .cam_y     (cam_y),
    .cam_z     (cam_z),
    .push      (q_push),
    .push_job  (q_in),
    .full      (q_full)
  );

  gtvw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(q_in),
    .full    (q_full),
    .pop     (q_pop),
    .pop_job (q_out),
    .avail   (q_avail)
  );

  gtvw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (q_avail),
    .q_job     (q_out),
    .pop       (q_pop),
    .tile_valid(tile_valid),
    .tile_stall(tile_stall),
    .tile_index(tile_index),
    .is_last   (is_last)
  );

  `GTVW_ASSERT(a_queue_no_overflow, !(q_push && q_full), "list queue written while full")
  `GTVW_ASSERT(a_queue_no_underflow, !(q_pop && !q_avail), "list queue read while empty")
  `GTVW_ASSERT_NEXT(a_cfg_holds_input, cfg_en, cam_stall, "camera taken right after a config write")

endmodule

>>> verif/grid_tile_view_window_checker.sv
// Predicts the tile lists of the grid tile view window and checks every tile transfer
`timescale 1ns / 100ps

module grid_tile_view_window_checker #(
  parameter int TILE_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_en,
  input  logic [gtvw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gtvw_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                cam_valid,
  input  logic                                cam_stall,
  input  logic signed [gtvw_pkg::COORD_W-1:0] cam_x,
  input  logic signed [gtvw_pkg::COORD_W-1:0] cam_y,
  input  logic signed [gtvw_pkg::COORD_W-1:0] cam_z,
  input  logic                                tile_valid,
  input  logic                                tile_stall,
  input  logic [gtvw_pkg::TILE_W-1:0]         tile_index,
  input  logic                                is_last,
  output int                                  mismatch_count,
  output int                                  tiles_outstanding
);
  import gtvw_pkg::*;

  typedef struct {
    logic [TILE_W-1:0] tile;
    logic              last;
  } tile_exp_t;

  tile_exp_t tiles_due[$];
  tile_exp_t head;
  int        fail_tally = 0;

  logic [SIDE_W-1:0]  rows_reg;
  logic [SIDE_W-1:0]  cols_reg;
  logic [RANGE_W-1:0] range_reg;
  int                 prev_x, prev_y, prev_z;
  bit                 first_pending, list_valid;
  int                 win_left, win_right, win_top, win_bottom, list_cols;
  logic [TILE_W-1:0]  own_tile;

  function automatic int side_of(logic [SIDE_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_SIDE) return MAX_SIDE;
    return int'(n);
  endfunction

  // Last column whose left edge lies strictly below x, or -1.
  function automatic int tile_col(int x, int cols);
    int col = -1;
    for (int i = 0; i < cols; i++)
      if (x > -cols * (TILE_WIDTH / 2) + i * TILE_WIDTH) col = i;
    return col;
  endfunction

  // Rows run toward negative z.
  function automatic int tile_row(int z, int rows);
    int row = -1;
    for (int j = 0; j < rows; j++)
      if (z < rows * (TILE_WIDTH / 2) - j * TILE_WIDTH) row = j;
    return row;
  endfunction

  task automatic predict_view(int x, int y, int z);
    longint            dx, dy, dz;
    int                rows, cols, reach, cx, cz, lft, rgt, top, bot, n, emit;
    logic [TILE_W-1:0] walk[$];
    logic [TILE_W-1:0] swap;
    tile_exp_t         due;
    dx = x - prev_x;
    dy = y - prev_y;
    dz = z - prev_z;
    if (first_pending || dx * dx + dy * dy + dz * dz >= MOVE_THRESHOLD) begin
      first_pending = 0;
      prev_x = x;
      prev_y = y;
      prev_z = z;
      rows  = side_of(rows_reg);
      cols  = side_of(cols_reg);
      reach = int'(range_reg);
      cx = tile_col(x, cols);
      cz = tile_row(z, rows);
      // off the grid: keep the old list
      if (cx >= 0 && cz >= 0) begin
        lft = tile_col(x - reach, cols);
        rgt = tile_col(x + reach, cols);
        top = tile_row(z + reach, rows);
        bot = tile_row(z - reach, rows);
        if (lft < 0) lft = 0;
        if (top < 0) top = 0;
        if (rgt >= cols) rgt = cols - 1;
        if (bot >= rows) bot = rows - 1;
        win_left   = lft;
        win_right  = rgt;
        win_top    = top;
        win_bottom = bot;
        own_tile   = TILE_W'(cx + cz * cols);
        list_cols  = cols;
        list_valid = 1;
      end
    end
    if (!list_valid) return;
    for (int i = win_left; i <= win_right && i < MAX_SIDE; i++)
      for (int j = win_top; j <= win_bottom && j < MAX_SIDE; j++)
        walk.insert(walk.size(), TILE_W'(i + j * list_cols));
    n = walk.size();
    if (n == 0) return;
    // move the camera's own tile to the end
    for (int k = 0; k < n; k++) begin
      if (walk[k] == own_tile) begin
        swap        = walk[k];
        walk[k]     = walk[n - 1];
        walk[n - 1] = swap;
      end
    end
    emit = (n < OUT_MAX) ? n : OUT_MAX;
    for (int k = 0; k + 1 < emit; k++) begin
      due.tile = walk[k];
      due.last = 1'b0;
      tiles_due.insert(tiles_due.size(), due);
    end
    due.tile = walk[n - 1];
    due.last = 1'b1;
    tiles_due.insert(tiles_due.size(), due);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_reg      = SIDE_W'(ROWS_RESET);
      cols_reg      = SIDE_W'(COLS_RESET);
      range_reg     = RANGE_W'(RANGE_RESET);
      prev_x        = 0;
      prev_y        = 0;
      prev_z        = 0;
      first_pending = 1;
      list_valid    = 0;
      win_left      = 0;
      win_right     = 0;
      win_top       = 0;
      win_bottom    = 0;
      own_tile      = '0;
      list_cols     = 0;
      tiles_due.delete();
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          REG_GRID_ROWS:  rows_reg  = cfg_data[SIDE_W-1:0];
          REG_GRID_COLS:  cols_reg  = cfg_data[SIDE_W-1:0];
          REG_VIEW_RANGE: range_reg = cfg_data[RANGE_W-1:0];
          default: ;
        endcase
      end
      if (tile_valid && !tile_stall) begin
        if (tiles_due.size() == 0) begin
          $error("tile_index: no tile expected, got %0d", tile_index);
          fail_tally++;
        end else begin
          head = tiles_due.pop_front();
          if (tile_index !== head.tile) begin
            $error("tile_index: expected %0d, got %0d", head.tile, tile_index);
            fail_tally++;
          end
          if (is_last !== head.last) begin
            $error("is_last: expected %0b, got %0b", head.last, is_last);
            fail_tally++;
          end
        end
      end
      if (cam_valid && !cam_stall) predict_view(int'(cam_x), int'(cam_y), int'(cam_z));
    end
    mismatch_count    <= fail_tally;
    tiles_outstanding <= tiles_due.size();
  end

endmodule

>>> verif/grid_tile_view_window_tb.sv
// Stimulus and verdict for the grid tile view window block
`timescale 1ns / 100ps

module grid_tile_view_window_tb;
  import gtvw_pkg::*;

  localparam int TILE = 1024;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_HEAVY, DRAIN_TOGGLE} drain_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_GRID_ROWS;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      cam_valid = 1'b0;
  logic                      cam_stall;
  logic signed [COORD_W-1:0] cam_x = '0;
  logic signed [COORD_W-1:0] cam_y = '0;
  logic signed [COORD_W-1:0] cam_z = '0;
  logic                      tile_valid;
  logic                      tile_stall = 1'b0;
  logic [TILE_W-1:0]         tile_index;
  logic                      is_last;
  int                        mismatch_count;
  int                        tiles_outstanding;

  int burst_left = 0;
  int last_x = 0, last_y = 0, last_z = 0;
  int span_rows = ROWS_RESET, span_cols = COLS_RESET;

  grid_tile_view_window #(.TILE_WIDTH(TILE)) dut (.*);

  grid_tile_view_window_checker #(.TILE_WIDTH(TILE)) tile_check (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("grid_tile_view_window test failed");
    $finish;
  end

  // receiver: stall on a pattern of its own, switching to a new random style after each random span
  initial begin : tile_drain
    drain_mode_t mode;
    int          span;
    forever begin
      mode = drain_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          DRAIN_FREE:  tile_stall <= 1'b0;
          DRAIN_COIN:  tile_stall <= ($urandom_range(0, 1) == 1);
          DRAIN_HEAVY: tile_stall <= ($urandom_range(0, 7) != 0);
          default:     tile_stall <= ~tile_stall;
        endcase
      end
    end
  end

  function automatic int spread(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clamp16(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // One transfer; closing drops valid right after it so the phase can end.
  task automatic send_cam(int x, int y, int z, bit closing);
    int gap;
    cam_valid <= 1'b1;
    cam_x     <= COORD_W'(x);
    cam_y     <= COORD_W'(y);
    cam_z     <= COORD_W'(z);
    last_x = x;
    last_y = y;
    last_z = z;
    @(posedge clk);
    while (cam_stall) @(posedge clk);
    if (closing || burst_left == 0) begin
      cam_valid <= 1'b0;
      if (!closing) begin
        gap = $urandom_range(1, 12);
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? spread(30, 60) : spread(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  // Wait out every expected tile, then cover items that emit nothing.
  task automatic settle();
    @(posedge clk);
    while (tiles_outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic configure(int rows, int cols, int reach);
    cfg_en    <= 1'b1;
    cfg_index <= REG_GRID_ROWS;
    cfg_data  <= {(CFG_W - SIDE_W)'($urandom), SIDE_W'(rows)};
    @(posedge clk);
    cfg_index <= REG_GRID_COLS;
    cfg_data  <= {(CFG_W - SIDE_W)'($urandom), SIDE_W'(cols)};
    @(posedge clk);
    cfg_index <= REG_VIEW_RANGE;
    cfg_data  <= CFG_W'(reach);
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_en <= 1'b0;
    span_rows = (rows == 0) ? 1 : ((rows > MAX_SIDE) ? MAX_SIDE : rows);
    span_cols = (cols == 0) ? 1 : ((cols > MAX_SIDE) ? MAX_SIDE : cols);
  endtask

  task automatic random_item(bit closing);
    int pick, x, y, z, hw, hh;
    hw   = span_cols * (TILE / 2);
    hh   = span_rows * (TILE / 2);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // anywhere on the grid
      x = spread(-hw, hw);
      y = spread(-2000, 2000);
      z = spread(-hh, hh);
    end else if (pick < 65) begin
      // small step around the move threshold
      x = last_x + spread(-25, 25);
      y = last_y + spread(-25, 25);
      z = last_z + spread(-25, 25);
    end else if (pick < 75) begin
      x = last_x;
      y = last_y;
      z = last_z;
    end else if (pick < 88) begin
      // straddle a tile edge
      x = -hw + spread(0, span_cols) * TILE + spread(-1, 1);
      y = last_y + spread(-30, 30);
      z = hh - spread(0, span_rows) * TILE + spread(-1, 1);
    end else begin
      x = int'(shortint'($urandom));
      y = int'(shortint'($urandom));
      z = int'(shortint'($urandom));
    end
    send_cam(clamp16(x), clamp16(y), clamp16(z), closing);
  endtask

  initial begin : stimulus
    int ph_rows[8]  = '{16, 1, 0, 31, 16, 3, 0, 0};
    int ph_cols[8]  = '{16, 1, 0, 17, 16, 5, 0, 0};
    int ph_reach[8] = '{1024, 0, 2047, 2047, 1500, 300, 0, 0};
    int per_phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset grid: 11 rows, 8 columns, range 800
    send_cam(-32768, 0, 0, 0);          // off grid before any list
    send_cam(32767, 32767, 32767, 0);   // off grid along z, still no list
    send_cam(0, 0, 0, 0);
    send_cam(5, -5, 5, 0);              // too small a move: same list
    send_cam(20, 0, 0, 0);              // move of exactly the threshold
    send_cam(20, 19, 0, 0);
    send_cam(20, 20, 0, 0);             // recompute on y alone
    send_cam(-4096, 0, 0, 0);           // left grid edge is off grid
    send_cam(-4095, 0, 5631, 0);
    send_cam(4095, 0, -5631, 0);
    send_cam(32767, 0, -32768, 0);
    send_cam(-1024, 0, 0, 0);
    send_cam(-1023, 0, 0, 0);
    send_cam(0, 0, 512, 0);
    send_cam(1, 0, 511, 0);
    send_cam(-32768, -32768, -32768, 0);
    send_cam(2000, -3000, 1000, 0);
    send_cam(-1, -1, -1, 1);
    settle();

    per_phase = 44;
    for (int p = 0; p < 8; p++) begin
      if (p >= 6) begin
        ph_rows[p]  = spread(0, 31);
        ph_cols[p]  = spread(0, 31);
        ph_reach[p] = spread(0, 2047);
      end
      configure(ph_rows[p], ph_cols[p], ph_reach[p]);
      for (int k = 0; k < per_phase; k++) random_item(k == per_phase - 1);
      settle();
    end

    if (mismatch_count == 0 && tiles_outstanding == 0)
      $display("grid_tile_view_window test passed");
    else
      $display("grid_tile_view_window test failed");
    $finish;
  end

endmodule
